/* sv/itrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared constants and the digit-to-character map of the radix text core.
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int unsigned IN_W    = 64;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CH_W    = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_A     = 8'h61;
  localparam logic [CH_W-1:0] CH_NONE  = 8'h00;

  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CH_W-1:0] dx;
    dx = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_A + dx - 8'd10;
    end
  endfunction

endpackage : itrt_pkg
`default_nettype wire

/* sv/itrt_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_divider
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
// ----------------------------------------------------------------------------
module itrt_divider #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               go,
  input  wire  [VALUE_BITS-1:0]             dividend,
  input  wire  [itrt_pkg::RADIX_W-1:0]      divisor,
  output logic                              done,
  output logic [VALUE_BITS-1:0]             quotient,
  output logic [itrt_pkg::DIGIT_W-1:0]      remainder
);

  localparam int unsigned SW = $clog2(VALUE_BITS + 1);

  logic [SW-1:0]                   step_r;
  logic                            done_r;
  logic [VALUE_BITS-1:0]           quo_r;
  logic [itrt_pkg::DIGIT_W-1:0]    rem_r;
  logic [itrt_pkg::DIGIT_W:0]      rem_sh;
  logic                            fits;
  logic [itrt_pkg::DIGIT_W:0]      rem_sub;

  assign rem_sh  = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (go) begin
      step_r <= SW'(VALUE_BITS);
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == SW'(1));
      if (step_r != '0) begin
        step_r <= step_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[VALUE_BITS-2:0], fits};
      rem_r <= fits ? rem_sub[itrt_pkg::DIGIT_W-1:0] : rem_sh[itrt_pkg::DIGIT_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule : itrt_divider
`default_nettype wire

/* sv/itrt_digit_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_digit_ram
// Digit buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itrt_digit_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [$clog2(DEPTH)-1:0]         waddr,
  input  wire  [itrt_pkg::DIGIT_W-1:0]     wdata,
  input  wire                              re,
  input  wire  [$clog2(DEPTH)-1:0]         raddr,
  output logic [itrt_pkg::DIGIT_W-1:0]     rdata
);

  logic [itrt_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [itrt_pkg::DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : itrt_digit_ram
`default_nettype wire

/* sv/integer_to_radix_text_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_text_core
// Converts an integer to lower-case ASCII text in base 2..36, MSD first.
// ----------------------------------------------------------------------------
// An invalid radix answers a start with one empty result on the next cycle and
// busy stays low. Otherwise the value is divided by the radix one quotient bit
// per cycle in a shared bit-serial divider, each remainder written to the
// digit buffer; after a turnaround state the characters come out of the buffer
// one per cycle, most significant first, preceded by '-' for a negative
// decimal value. Results are strobed for one cycle each by out_valid and
// cannot be held off.
// ----------------------------------------------------------------------------
module integer_to_radix_text_core #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [itrt_pkg::IN_W-1:0]        in_value,
  output logic                             out_valid,
  output logic [itrt_pkg::CH_W-1:0]        out_ch,
  output logic                             out_last,
  output logic                             out_empty_res,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [itrt_pkg::RADIX_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(VALUE_BITS);
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TURN,
    ST_OUT
  } state_t;

  state_t                          state_r;
  logic [itrt_pkg::RADIX_W-1:0]    radix_r;
  logic                            signed_mode_r;
  logic [CW-1:0]                   cnt_r;
  logic [AW-1:0]                   addr_r;
  logic                            sign_r;
  logic                            out_valid_r;
  logic [itrt_pkg::CH_W-1:0]       out_ch_r;
  logic                            out_last_r;
  logic                            out_empty_r;

  logic                            accept;
  logic                            radix_ok;
  logic [VALUE_BITS-1:0]           val;
  logic                            neg;
  logic [VALUE_BITS-1:0]           mag;
  logic                            div_go;
  logic [VALUE_BITS-1:0]           div_dividend;
  logic                            div_done;
  logic [VALUE_BITS-1:0]           div_quo;
  logic [itrt_pkg::DIGIT_W-1:0]    div_rem;
  logic                            ram_we;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [itrt_pkg::DIGIT_W-1:0]    ram_rdata;
  logic [CW-1:0]                   cnt_dec;

  assign accept   = start && (state_r == ST_IDLE);
  assign radix_ok = (radix_r >= itrt_pkg::RADIX_MIN) && (radix_r <= itrt_pkg::RADIX_MAX);
  assign val      = in_value[VALUE_BITS-1:0];
  assign neg      = signed_mode_r && val[VALUE_BITS-1];
  assign mag      = neg ? (~val + VALUE_BITS'(1)) : val;
  assign cnt_dec  = cnt_r - CW'(1);

  always_comb begin
    div_go       = 1'b0;
    div_dividend = mag;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cnt_dec[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        div_go = accept && radix_ok;
      end
      ST_DIV: begin
        ram_we       = div_done;
        div_go       = div_done && (div_quo != '0);
        div_dividend = div_quo;
      end
      ST_TURN: begin
        ram_re = 1'b1;
      end
      ST_OUT: begin
        ram_re    = (addr_r != '0);
        ram_raddr = addr_r - AW'(1);
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  itrt_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  itrt_digit_ram #(
    .DEPTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= itrt_pkg::RADIX_DEC;
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == itrt_pkg::REG_RADIX) begin
        radix_r <= cfg_data;
      end else begin
        signed_mode_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      addr_r      <= '0;
      sign_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_ch_r    <= itrt_pkg::CH_NONE;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (radix_ok) begin
              cnt_r   <= '0;
              sign_r  <= neg && (radix_r == itrt_pkg::RADIX_DEC);
              state_r <= ST_DIV;
            end else begin
              out_valid_r <= 1'b1;
              out_ch_r    <= itrt_pkg::CH_NONE;
              out_last_r  <= 1'b1;
              out_empty_r <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cnt_r <= cnt_r + CW'(1);
            if (div_quo == '0) begin
              state_r <= ST_TURN;
            end
          end
        end
        ST_TURN: begin
          addr_r  <= cnt_dec[AW-1:0];
          state_r <= ST_OUT;
          if (sign_r) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= itrt_pkg::CH_MINUS;
          end
        end
        ST_OUT: begin
          out_valid_r <= 1'b1;
          out_ch_r    <= itrt_pkg::digit_char(ram_rdata);
          out_last_r  <= (addr_r == '0);
          addr_r      <= addr_r - AW'(1);
          if (addr_r == '0) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ch        = out_ch_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

`ifndef NO_ASSERTIONS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && (out_ch == itrt_pkg::CH_NONE))
    else $error("empty result without last flag");

  a_quiet_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !out_valid)
    else $error("result strobed during division");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VALUE_BITS))
    else $error("digit count overflow");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && (addr_r == '0) |=> out_valid && out_last && !busy)
    else $error("final character not flagged");
`endif

endmodule : integer_to_radix_text_core
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks integer_to_radix_text_core against a behavioral predictor of itoa.
// Directed values cover zero, all-ones, the most negative value and the
// largest positive one, the radix extremes 2, 36, 0, 1, 37 and 63, and the
// sign rules in and outside base 10. Random phases then pick a setting and
// send values of random bit length, some sign-extended. Each character
// strobed out is compared with the oldest predicted one, with random start
// gaps and a watchdog on stalled transfers.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned ITEM_GOAL   = 380;

  typedef logic [itrt_pkg::CH_W-1:0]    ch_t;
  typedef logic [itrt_pkg::IN_W-1:0]    in_t;
  typedef logic [itrt_pkg::DIGIT_W-1:0] digit_t;
  typedef logic [itrt_pkg::RADIX_W-1:0] radix_t;

  typedef struct packed {
    ch_t  ch;
    logic last;
    logic empty_res;
  } text_char_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  in_t    in_value = '0;
  logic   out_valid;
  ch_t    out_ch;
  logic   out_last;
  logic   out_empty_res;
  logic   cfg_we = 1'b0;
  logic   cfg_index = itrt_pkg::REG_RADIX;
  radix_t cfg_data = '0;

  radix_t radix_m = itrt_pkg::RADIX_DEC;
  logic   signed_m = 1'b1;

  in_t        pending_values[$];
  in_t        staged_values[$];
  text_char_t expected_chars[$];
  text_char_t mon_exp;

  bit          no_gaps = 1'b0;
  int unsigned idle_gap = 0;
  int unsigned drv_gap;
  int unsigned quiet_cycles = 0;
  int unsigned n_values = 0;
  int unsigned n_chars = 0;
  int unsigned n_fail = 0;
  int unsigned n_settings = 0;

  integer_to_radix_text_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ch        (out_ch),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void predict_text(input in_t value);
    in_t         mag;
    digit_t      digits[64];
    digit_t      d;
    bit          neg;
    int unsigned nd;
    text_char_t  c;
    if (radix_m < itrt_pkg::RADIX_MIN || radix_m > itrt_pkg::RADIX_MAX) begin
      c.ch        = itrt_pkg::CH_NONE;
      c.last      = 1'b1;
      c.empty_res = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    neg = signed_m && value[itrt_pkg::IN_W-1];
    mag = neg ? -value : value;
    nd  = 0;
    do begin
      digits[nd] = digit_t'(mag % in_t'(radix_m));
      nd++;
      mag = mag / in_t'(radix_m);
    end while (mag != '0);
    c.empty_res = 1'b0;
    if (neg && radix_m == itrt_pkg::RADIX_DEC) begin
      c.ch   = itrt_pkg::CH_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      d      = digits[k];
      c.ch   = (d < 10) ? itrt_pkg::CH_ZERO + ch_t'(d)
                        : itrt_pkg::CH_A + ch_t'(d) - ch_t'(10);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // feed values from the pending queue, one start per transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      idle_gap <= 0;
    end else if (start && !busy) begin
      predict_text(in_value);
      n_values <= n_values + 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: drv_gap = 0;
        6, 7, 8:          drv_gap = $urandom_range(1, 4);
        default:          drv_gap = $urandom_range(8, 60);
      endcase
      if (no_gaps) begin
        drv_gap = 0;
      end
      if (drv_gap == 0 && pending_values.size() != 0) begin
        in_value <= pending_values.pop_front();
      end else begin
        start    <= 1'b0;
        in_value <= {$urandom, $urandom};
        idle_gap <= drv_gap;
      end
    end else if (!start) begin
      if (idle_gap != 0) begin
        idle_gap <= idle_gap - 1;
      end else if (pending_values.size() != 0) begin
        start    <= 1'b1;
        in_value <= pending_values.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_chars <= n_chars + 1;
      if (expected_chars.size() == 0) begin
        $error("unexpected transfer: ch=%h last=%b empty_res=%b",
               out_ch, out_last, out_empty_res);
        n_fail++;
      end else begin
        mon_exp = expected_chars.pop_front();
        if (out_ch !== mon_exp.ch) begin
          $error("ch: expected %h actual %h", mon_exp.ch, out_ch);
          n_fail++;
        end
        if (out_last !== mon_exp.last) begin
          $error("last: expected %b actual %b", mon_exp.last, out_last);
          n_fail++;
        end
        if (out_empty_res !== mon_exp.empty_res) begin
          $error("empty_res: expected %b actual %b", mon_exp.empty_res, out_empty_res);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_values.size() != 0 || start || busy || expected_chars.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input radix_t r, input logic s);
    cfg_we    <= 1'b1;
    cfg_index <= itrt_pkg::REG_RADIX;
    cfg_data  <= r;
    @(posedge clk);
    radix_m   = r;
    cfg_index <= itrt_pkg::REG_SIGNED;
    cfg_data  <= {{(itrt_pkg::RADIX_W-1){1'b0}}, s};
    @(posedge clk);
    signed_m  = s;
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input bit do_cfg, input radix_t r, input logic s);
    if (do_cfg) begin
      set_config(r, s);
    end
    n_settings++;
    @(negedge clk);
    while (staged_values.size() != 0) begin
      pending_values.push_back(staged_values.pop_front());
    end
    wait_idle();
  endtask

  initial begin : stimulus
    in_t         v;
    in_t         m;
    radix_t      r;
    int unsigned w;
    int unsigned n;
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: signed decimal
    staged_values = '{64'd0, 64'd1, '1, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 64'd1234567890};
    run_phase(1'b0, itrt_pkg::RADIX_DEC, 1'b1);
    staged_values = '{'1, 64'd0, {1'b1, 63'd0}};
    run_phase(1'b1, 6'd2, 1'b0);
    staged_values = '{{1'b1, 63'd0}, '1, 64'd35, 64'd36};
    run_phase(1'b1, 6'd36, 1'b1);
    staged_values = '{64'hffff_ffff_ffff_ff00, {1'b1, 63'd0}};
    run_phase(1'b1, 6'd16, 1'b1);
    staged_values = '{'1};
    run_phase(1'b1, itrt_pkg::RADIX_DEC, 1'b0);
    staged_values = '{64'd5};
    run_phase(1'b1, 6'd0, 1'b1);
    staged_values = '{'1};
    run_phase(1'b1, 6'd1, 1'b0);
    staged_values = '{64'd77};
    run_phase(1'b1, 6'd37, 1'b1);
    staged_values = '{64'd0, '1, 64'd9};
    run_phase(1'b1, 6'd63, 1'b0);

    while (n_values < ITEM_GOAL) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0:       r = 6'd0;
          1:       r = 6'd1;
          default: r = radix_t'($urandom_range(37, 63));
        endcase
      end else if (pick == 1) begin
        r = $urandom_range(0, 1) ? itrt_pkg::RADIX_MAX : itrt_pkg::RADIX_MIN;
      end else if (pick == 2) begin
        r = itrt_pkg::RADIX_DEC;
      end else begin
        r = radix_t'($urandom_range(2, 36));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 24);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 4) begin
          v = '0;
        end else if (pick < 7) begin
          v = {1'b1, 63'd0};
        end else if (pick < 10) begin
          v = '1;
        end else begin
          w = $urandom_range(1, 64);
          m = (w == 64) ? '1 : (64'd1 << w) - 64'd1;
          v &= m;
          if ($urandom_range(0, 4) == 0) begin
            v |= ~m;
          end
        end
        staged_values.push_back(v);
      end
      run_phase(1'b1, r, 1'($urandom_range(0, 1)));
    end

    repeat (100) @(posedge clk);
    $display("summary: %0d values in %0d radix/sign settings, %0d characters checked",
             n_values, n_settings, n_chars);
    if (n_fail == 0 && expected_chars.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule : testbench
